// File: sv/prmsp_pkg.sv
// Package for the poll-rate micro-step planner: widths, constants, sequencer states.
package prmsp_pkg;

  // Defaults for the top-level parameters.
  localparam int unsigned RING_DEPTH_DEF    = 64;
  localparam int unsigned MAX_STEPS_DEF     = 8;
  localparam int unsigned MAX_OUTPUT_HZ_DEF = 64000;

  // Field widths.
  localparam int unsigned RATE_W  = 16;
  localparam int unsigned STEPS_W = 7;
  localparam int unsigned VHZ_W   = 22;

  // Shared divider widths: 1e6 needs 20 bits, the divisor is a 16-bit rate or interval.
  localparam int unsigned DVD_W = 20;
  localparam int unsigned DVS_W = 16;

  localparam logic [RATE_W-1:0] DT_MIN_US       = 16'd20;
  localparam logic [RATE_W-1:0] DT_MAX_US       = 16'd50000;
  localparam logic [DVD_W-1:0]  US_PER_S        = 20'd1000000;
  localparam logic [RATE_W-1:0] PEAK_LO_HZ      = 16'd125;
  localparam logic [RATE_W-1:0] PEAK_HI_HZ      = 16'd24000;
  localparam logic [RATE_W-1:0] DEFAULT_HZ      = 16'd1000;
  localparam logic [RATE_W-1:0] TARGET_LO_HZ    = 16'd1000;
  localparam logic [RATE_W-1:0] TARGET_HI_HZ    = 16'd8000;
  localparam logic [RATE_W-1:0] FORCE_TARGET_HZ = 16'd7500;
  localparam logic [RATE_W-1:0] FORCE_RATE_HZ   = 16'd3200;
  localparam logic [RATE_W-1:0] VRATE_RESET     = 16'd8000;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_PEAK_DIV,
    ST_PLAN,
    ST_STEP_DIV,
    ST_MUL,
    ST_FINISH
  } state_e;

endpackage

// File: sv/prmsp_div.sv
// Iterative restoring divider, one quotient bit per cycle.
module prmsp_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [prmsp_pkg::DVD_W-1:0]   dividend_i,
  input  logic [prmsp_pkg::DVS_W-1:0]   divisor_i,
  output logic                          done_o,
  output logic [prmsp_pkg::DVD_W-1:0]   quotient_o
);

  localparam int unsigned DVD_W = prmsp_pkg::DVD_W;
  localparam int unsigned DVS_W = prmsp_pkg::DVS_W;
  localparam int unsigned CNT_W = $clog2(DVD_W);
  localparam logic [CNT_W-1:0] LAST = CNT_W'(DVD_W - 1);

  logic             busy_q;
  logic             done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [DVD_W-1:0] quo_q, quo_d;
  logic [DVS_W-1:0] rem_q, rem_d;
  logic [DVS_W-1:0] dvs_q;
  logic [DVS_W:0]   shifted;
  logic [DVS_W:0]   diff;

  always_comb begin
    shifted = {rem_q, quo_q[DVD_W-1]};
    diff    = shifted - {1'b0, dvs_q};
    if (shifted >= {1'b0, dvs_q}) begin
      rem_d = diff[DVS_W-1:0];
      quo_d = {quo_q[DVD_W-2:0], 1'b1};
    end else begin
      rem_d = shifted[DVS_W-1:0];
      quo_d = {quo_q[DVD_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == LAST);
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        if (cnt_q == LAST) begin
          busy_q <= 1'b0;
        end
        cnt_q <= cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

// File: sv/poll_rate_micro_step_planner_top.sv
// Top level of the poll-rate micro-step planner: ring, scan sequencer, planning datapath.
//
// Usage:
//  - Input stream (s_axis_*): tuser carries the operation (0 record, 1 query).
//    A record transfer writes interval_us into the ring and gives no output.
//    A query scans the stored intervals, derives the peak rate and the
//    micro-step plan, and gives one output transfer.
//  - Output stream (m_axis_*): one transfer per query; tuser flags fallback.
//  - Config channel (cfg_*): always ready; writes the virtual rate limit.
//    Write it only while no query is in flight.
//  - Query sequence: the scan reads one stored interval per cycle through the single
//    memory read port; when a valid interval is found, the shared divider then
//    runs two passes (20 quotient steps each), followed by the plan, multiply
//    and output load steps. On fallback the peak divide is skipped.
//  - Throughput: records one per cycle while the block is idle; the input is not
//    ready while a query is being worked on, so a new query waits until the
//    previous one has loaded its result.
//  - Stall: the result sits in an output register; the block returns to idle
//    and keeps taking records, and a later query waits in its final step
//    until the previous result has been taken.
//  - Reset: ring pointer and fill count clear, the limit returns to 8000 Hz;
//    ring contents stay undefined, but only written entries are ever scanned.
module poll_rate_micro_step_planner_top #(
  parameter int unsigned RING_DEPTH    = prmsp_pkg::RING_DEPTH_DEF,
  parameter int unsigned MAX_STEPS     = prmsp_pkg::MAX_STEPS_DEF,
  parameter int unsigned MAX_OUTPUT_HZ = prmsp_pkg::MAX_OUTPUT_HZ_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input stream
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [47:0] s_axis_tdata_i,   // interval_us, physical_hz, reported_hz
  input  logic [0:0]  s_axis_tuser_i,   // operation
  // output stream
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [47:0] m_axis_tdata_o,   // micro_steps, virtual_hz, peak_hz, zero pad
  output logic [0:0]  m_axis_tuser_o,   // used_fallback
  // configuration write
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i        // virtual_rate_limit
);

  localparam int unsigned RATE_W  = prmsp_pkg::RATE_W;
  localparam int unsigned STEPS_W = prmsp_pkg::STEPS_W;
  localparam int unsigned VHZ_W   = prmsp_pkg::VHZ_W;
  localparam int unsigned DVD_W   = prmsp_pkg::DVD_W;
  localparam int unsigned PROD_W  = RATE_W + STEPS_W;
  localparam int unsigned PTR_W   = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int unsigned CNT_W   = $clog2(RING_DEPTH + 1);

  localparam logic [PTR_W-1:0]   PTR_LAST   = PTR_W'(RING_DEPTH - 1);
  localparam logic [CNT_W-1:0]   FILL_FULL  = CNT_W'(RING_DEPTH);
  localparam logic [STEPS_W-1:0] STEPS_MAX  = STEPS_W'(MAX_STEPS);
  localparam logic [PROD_W-1:0]  VHZ_CAP    = PROD_W'(MAX_OUTPUT_HZ);

  typedef prmsp_pkg::state_e state_e;

  state_e state_q, state_d;

  // ring
  logic [RATE_W-1:0] ring_mem [RING_DEPTH];
  logic [RATE_W-1:0] rd_data_q;
  logic              rd_vld_q;
  logic [PTR_W-1:0]  wp_q;
  logic [CNT_W-1:0]  fill_q;
  logic [CNT_W-1:0]  idx_q;

  // query operands and planning registers
  logic [RATE_W-1:0]  phys_q, rep_q;
  logic [RATE_W-1:0]  best_q;
  logic [RATE_W-1:0]  peak_q;
  logic               fb_q;
  logic [RATE_W-1:0]  rate_q, srate_q;
  logic [STEPS_W-1:0] steps_q;
  logic [PROD_W-1:0]  prod_q;
  logic [RATE_W-1:0]  vlimit_q;

  // output register
  logic               out_vld_q;
  logic [STEPS_W-1:0] out_steps_q;
  logic [VHZ_W-1:0]   out_vhz_q;
  logic [RATE_W-1:0]  out_peak_q;
  logic               out_fb_q;

  // shared divider
  logic               div_start;
  logic [DVD_W-1:0]   div_dvd;
  logic [RATE_W-1:0]  div_dvs;
  logic               div_done;
  logic [DVD_W-1:0]   div_quo;

  logic in_xfer, rec_xfer, qry_xfer, out_xfer;
  logic scan_end;
  logic in_range;
  logic [RATE_W-1:0] target;
  logic [RATE_W-1:0] rate_max, rate_c, srate_c;
  logic [RATE_W-1:0] peak_div;
  logic [STEPS_W-1:0] steps_c;
  logic              load_out;

  assign s_axis_tready_o = (state_q == prmsp_pkg::ST_IDLE);
  assign cfg_ready_o     = 1'b1;
  assign in_xfer  = s_axis_tvalid_i && s_axis_tready_o;
  assign rec_xfer = in_xfer && !s_axis_tuser_i[0];
  assign qry_xfer = in_xfer && s_axis_tuser_i[0];
  assign out_xfer = out_vld_q && m_axis_tready_i;

  assign scan_end = (idx_q == fill_q) && !rd_vld_q;
  assign in_range = (rd_data_q >= prmsp_pkg::DT_MIN_US) && (rd_data_q <= prmsp_pkg::DT_MAX_US);

  // planning arithmetic
  always_comb begin
    target = vlimit_q;
    if (target < prmsp_pkg::TARGET_LO_HZ) begin
      target = prmsp_pkg::TARGET_LO_HZ;
    end else if (target > prmsp_pkg::TARGET_HI_HZ) begin
      target = prmsp_pkg::TARGET_HI_HZ;
    end
    rate_max = (peak_q > phys_q) ? peak_q : phys_q;
    rate_c   = (rate_max < prmsp_pkg::PEAK_LO_HZ) ? prmsp_pkg::DEFAULT_HZ : rate_max;
    srate_c  = (rate_c > prmsp_pkg::PEAK_HI_HZ) ? prmsp_pkg::PEAK_HI_HZ : rate_c;

    // peak from 1e6 / best, clamped to 125..24000
    if (div_quo > DVD_W'(prmsp_pkg::PEAK_HI_HZ)) begin
      peak_div = prmsp_pkg::PEAK_HI_HZ;
    end else if (div_quo < DVD_W'(prmsp_pkg::PEAK_LO_HZ)) begin
      peak_div = prmsp_pkg::PEAK_LO_HZ;
    end else begin
      peak_div = div_quo[RATE_W-1:0];
    end

    // step count: ceil quotient clamped, then forced to the maximum when target >= 7500 Hz and srate < 3200 Hz
    if (div_quo == '0) begin
      steps_c = STEPS_W'(1);
    end else if (div_quo > DVD_W'(MAX_STEPS)) begin
      steps_c = STEPS_MAX;
    end else begin
      steps_c = div_quo[STEPS_W-1:0];
    end
    if ((target >= prmsp_pkg::FORCE_TARGET_HZ) && (steps_c < STEPS_MAX)
        && (srate_q < prmsp_pkg::FORCE_RATE_HZ)) begin
      steps_c = STEPS_MAX;
    end
  end

  // sequencer
  always_comb begin
    state_d   = state_q;
    div_start = 1'b0;
    div_dvd   = prmsp_pkg::US_PER_S;
    div_dvs   = best_q;
    load_out  = 1'b0;
    unique case (state_q)
      prmsp_pkg::ST_IDLE: begin
        if (qry_xfer) begin
          state_d = prmsp_pkg::ST_SCAN;
        end
      end
      prmsp_pkg::ST_SCAN: begin
        if (scan_end) begin
          if (best_q == '0) begin
            state_d = prmsp_pkg::ST_PLAN;
          end else begin
            div_start = 1'b1;
            state_d   = prmsp_pkg::ST_PEAK_DIV;
          end
        end
      end
      prmsp_pkg::ST_PEAK_DIV: begin
        if (div_done) begin
          state_d = prmsp_pkg::ST_PLAN;
        end
      end
      prmsp_pkg::ST_PLAN: begin
        div_start = 1'b1;
        div_dvd   = DVD_W'(target) + DVD_W'(srate_c) - DVD_W'(1);
        div_dvs   = srate_c;
        state_d   = prmsp_pkg::ST_STEP_DIV;
      end
      prmsp_pkg::ST_STEP_DIV: begin
        if (div_done) begin
          state_d = prmsp_pkg::ST_MUL;
        end
      end
      prmsp_pkg::ST_MUL: begin
        state_d = prmsp_pkg::ST_FINISH;
      end
      prmsp_pkg::ST_FINISH: begin
        if (!out_vld_q || m_axis_tready_i) begin
          load_out = 1'b1;
          state_d  = prmsp_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = prmsp_pkg::ST_IDLE;
      end
    endcase
  end

  prmsp_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dvs),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  // ring memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (rec_xfer) begin
      ring_mem[wp_q] <= s_axis_tdata_i[15:0];
    end
    rd_data_q <= ring_mem[idx_q[PTR_W-1:0]];
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= prmsp_pkg::ST_IDLE;
      wp_q      <= '0;
      fill_q    <= '0;
      idx_q     <= '0;
      rd_vld_q  <= 1'b0;
      vlimit_q  <= prmsp_pkg::VRATE_RESET;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) begin
        vlimit_q <= cfg_data_i;
      end
      if (rec_xfer) begin
        wp_q <= (wp_q == PTR_LAST) ? '0 : wp_q + 1'b1;
        if (fill_q != FILL_FULL) begin
          fill_q <= fill_q + 1'b1;
        end
      end
      if (qry_xfer) begin
        idx_q    <= '0;
        rd_vld_q <= 1'b0;
      end else if (state_q == prmsp_pkg::ST_SCAN) begin
        rd_vld_q <= (idx_q != fill_q);
        if (idx_q != fill_q) begin
          idx_q <= idx_q + 1'b1;
        end
      end
      if (load_out) begin
        out_vld_q <= 1'b1;
      end else if (out_xfer) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (qry_xfer) begin
      phys_q <= s_axis_tdata_i[31:16];
      rep_q  <= s_axis_tdata_i[47:32];
      best_q <= '0;
    end
    if ((state_q == prmsp_pkg::ST_SCAN) && rd_vld_q && in_range
        && ((best_q == '0) || (rd_data_q < best_q))) begin
      best_q <= rd_data_q;
    end
    if ((state_q == prmsp_pkg::ST_SCAN) && scan_end) begin
      fb_q   <= (best_q == '0);
      peak_q <= (rep_q > RATE_W'(1)) ? rep_q : prmsp_pkg::DEFAULT_HZ;
    end
    if ((state_q == prmsp_pkg::ST_PEAK_DIV) && div_done) begin
      peak_q <= peak_div;
    end
    if (state_q == prmsp_pkg::ST_PLAN) begin
      rate_q  <= rate_c;
      srate_q <= srate_c;
    end
    if ((state_q == prmsp_pkg::ST_STEP_DIV) && div_done) begin
      steps_q <= steps_c;
    end
    if (state_q == prmsp_pkg::ST_MUL) begin
      prod_q <= PROD_W'(rate_q) * PROD_W'(steps_q);
    end
    if (load_out) begin
      out_steps_q <= steps_q;
      out_vhz_q   <= (prod_q > VHZ_CAP) ? VHZ_CAP[VHZ_W-1:0] : prod_q[VHZ_W-1:0];
      out_peak_q  <= peak_q;
      out_fb_q    <= fb_q;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {3'b000, out_peak_q, out_vhz_q, out_steps_q};
  assign m_axis_tuser_o  = out_fb_q;

  // checks
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FILL_FULL)
    else $error("ring fill count beyond ring depth");

  a_scan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == prmsp_pkg::ST_SCAN) |-> (idx_q <= fill_q))
    else $error("scan index passed the fill count");

  a_div_owner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> ((state_q == prmsp_pkg::ST_PEAK_DIV) || (state_q == prmsp_pkg::ST_STEP_DIV)))
    else $error("divider finished outside a divide step");

  a_steps_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_vld_q) |-> ((out_steps_q >= STEPS_W'(1)) && (out_steps_q <= STEPS_MAX)))
    else $error("step count out of range");

  a_peak_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($rose(out_vld_q) && !out_fb_q) |->
      ((out_peak_q >= prmsp_pkg::PEAK_LO_HZ) && (out_peak_q <= prmsp_pkg::PEAK_HI_HZ)))
    else $error("measured peak outside clamp range");

endmodule

// File: dv/tb_top.sv
// Self-checking testbench for the poll-rate micro-step planner: interval records and plan queries.
`timescale 1ns / 100ps

module tb_top;

  localparam int unsigned RING_DEPTH     = prmsp_pkg::RING_DEPTH_DEF;
  localparam int unsigned MAX_STEPS      = prmsp_pkg::MAX_STEPS_DEF;
  localparam int unsigned MAX_OUTPUT_HZ  = prmsp_pkg::MAX_OUTPUT_HZ_DEF;
  localparam int unsigned RATE_W         = prmsp_pkg::RATE_W;
  localparam int unsigned STEPS_W        = prmsp_pkg::STEPS_W;
  localparam int unsigned VHZ_W          = prmsp_pkg::VHZ_W;
  localparam int unsigned PHASE_ITEMS    = 150;
  localparam int unsigned BAND_ITEMS     = 100;
  localparam int unsigned SETTLE_CYCLES  = 8;
  localparam int unsigned TAIL_CYCLES    = 120;
  localparam int unsigned WATCHDOG_LIMIT = 4000;

  typedef enum logic {
    OP_RECORD = 1'b0,
    OP_QUERY  = 1'b1
  } plan_op_e;

  typedef struct packed {
    plan_op_e          op;
    logic [RATE_W-1:0] interval_us;
    logic [RATE_W-1:0] physical_hz;
    logic [RATE_W-1:0] reported_hz;
  } plan_item_t;

  typedef struct packed {
    logic [STEPS_W-1:0] micro_steps;
    logic [VHZ_W-1:0]   virtual_hz;
    logic [RATE_W-1:0]  peak_hz;
    logic               used_fallback;
  } plan_result_t;

  // Shadow of the planner: interval ring, fill state, rate limit, pending plans.
  class plan_scoreboard;
    logic [RATE_W-1:0] ring [RING_DEPTH];
    int unsigned       wr_ptr;
    int unsigned       fill;
    logic [15:0]       rate_limit;
    plan_result_t      plans_q[$];
    int unsigned       failures;

    function new();
      wr_ptr     = 0;
      fill       = 0;
      rate_limit = prmsp_pkg::VRATE_RESET;
      failures   = 0;
    endfunction

    function void write_limit(logic [15:0] value);
      rate_limit = value;
    endfunction

    function int unsigned pending();
      return plans_q.size();
    endfunction

    // Record: store the interval. Query: work out the plan the block must give.
    function void note_input(plan_item_t it);
      int unsigned  best;
      int unsigned  dt;
      int unsigned  peak;
      int unsigned  rate;
      int unsigned  srate;
      int unsigned  target;
      int unsigned  steps;
      int unsigned  vhz;
      plan_result_t plan;
      if (it.op == OP_RECORD) begin
        ring[wr_ptr] = it.interval_us;
        wr_ptr = (wr_ptr + 1) % RING_DEPTH;
        if (fill < RING_DEPTH) fill++;
        return;
      end
      // shortest in-range interval among the written entries
      best = 0;
      for (int unsigned i = 0; i < fill; i++) begin
        dt = ring[i];
        if (dt >= prmsp_pkg::DT_MIN_US && dt <= prmsp_pkg::DT_MAX_US &&
            (best == 0 || dt < best)) best = dt;
      end
      if (best == 0) begin
        // fallback is not clamped
        plan.used_fallback = 1'b1;
        peak = (it.reported_hz > 1) ? it.reported_hz : prmsp_pkg::DEFAULT_HZ;
      end else begin
        plan.used_fallback = 1'b0;
        peak = prmsp_pkg::US_PER_S / best;
        if (peak < prmsp_pkg::PEAK_LO_HZ) peak = prmsp_pkg::PEAK_LO_HZ;
        if (peak > prmsp_pkg::PEAK_HI_HZ) peak = prmsp_pkg::PEAK_HI_HZ;
      end
      rate = (peak > it.physical_hz) ? peak : it.physical_hz;
      if (rate < prmsp_pkg::PEAK_LO_HZ) rate = prmsp_pkg::DEFAULT_HZ;
      srate = (rate > prmsp_pkg::PEAK_HI_HZ) ? prmsp_pkg::PEAK_HI_HZ : rate;
      target = rate_limit;
      if (target < prmsp_pkg::TARGET_LO_HZ) target = prmsp_pkg::TARGET_LO_HZ;
      if (target > prmsp_pkg::TARGET_HI_HZ) target = prmsp_pkg::TARGET_HI_HZ;
      steps = (target + srate - 1) / srate;
      if (steps < 1) steps = 1;
      if (steps > MAX_STEPS) steps = MAX_STEPS;
      // slow clamped rate with a high target: go straight to the step ceiling
      if (target >= prmsp_pkg::FORCE_TARGET_HZ && steps < MAX_STEPS &&
          srate < prmsp_pkg::FORCE_RATE_HZ)
        steps = MAX_STEPS;
      vhz = rate * steps;  // full rate, not the clamped one
      if (vhz > MAX_OUTPUT_HZ) vhz = MAX_OUTPUT_HZ;
      plan.micro_steps = steps[STEPS_W-1:0];
      plan.virtual_hz  = vhz[VHZ_W-1:0];
      plan.peak_hz     = peak[RATE_W-1:0];
      plans_q.push_back(plan);
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
        failures++;
      end
    endfunction

    function void check_result(logic [47:0] data, logic [0:0] user);
      plan_result_t want;
      if (plans_q.size() == 0) begin
        $display("%0t: plan result with none pending, expected nothing actual tdata=%h tuser=%b",
                 $time, data, user);
        failures++;
        return;
      end
      want = plans_q.pop_front();
      compare_field("micro_steps", 32'(want.micro_steps), 32'(data[6:0]));
      compare_field("virtual_hz", 32'(want.virtual_hz), 32'(data[28:7]));
      compare_field("peak_hz", 32'(want.peak_hz), 32'(data[44:29]));
      compare_field("tdata pad", 32'd0, 32'(data[47:45]));
      compare_field("used_fallback", 32'(want.used_fallback), 32'(user));
    endfunction
  endclass

  logic        clk_i           = 1'b0;
  logic        rst_ni          = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [47:0] s_axis_tdata_i  = '0;   // interval_us, physical_hz, reported_hz
  logic [0:0]  s_axis_tuser_i  = '0;   // operation
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [47:0] m_axis_tdata_o;         // micro_steps, virtual_hz, peak_hz, zero pad
  logic [0:0]  m_axis_tuser_o;         // used_fallback
  logic        cfg_valid_i     = 1'b0;
  logic        cfg_ready_o;
  logic [15:0] cfg_data_i      = '0;   // virtual_rate_limit

  plan_scoreboard sb = new();

  int unsigned burst_left = 0;
  int unsigned stall_hold = 0;

  poll_rate_micro_step_planner_top dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_data_i      (cfg_data_i)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Receiver: long ready stretches, long stalls, and cycle-by-cycle noise.
  always @(posedge clk_i) begin
    if (stall_hold != 0) begin
      stall_hold--;
    end else begin
      case ($urandom_range(0, 3))
        0: begin
          m_axis_tready_i <= 1'b1;
          stall_hold = $urandom_range(20, 80);
        end
        1: begin
          m_axis_tready_i <= 1'b0;
          stall_hold = $urandom_range(1, 40);
        end
        default: begin
          m_axis_tready_i <= 1'($urandom_range(0, 1));
        end
      endcase
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i)
      sb.check_result(m_axis_tdata_o, m_axis_tuser_o);
  end

  // Ends the run when no transfer of any kind happens for too long.
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i) ||
          (cfg_valid_i && cfg_ready_o))
        quiet = 0;
      else
        quiet++;
    end
    $display("%0t: watchdog expired with %0d plans pending", $time, sb.pending());
    $display("CHECK FAILED");
    $finish;
  end

  function automatic plan_item_t record_item(logic [15:0] interval);
    plan_item_t it;
    it.op          = OP_RECORD;
    it.interval_us = interval;
    it.physical_hz = 16'($urandom);
    it.reported_hz = 16'($urandom);
    return it;
  endfunction

  function automatic plan_item_t query_item(logic [15:0] physical, logic [15:0] reported);
    plan_item_t it;
    it.op          = OP_QUERY;
    it.interval_us = 16'($urandom);
    it.physical_hz = physical;
    it.reported_hz = reported;
    return it;
  endfunction

  // Mostly records from the current interval band, some out of range, ~15% queries.
  function automatic plan_item_t random_item(int unsigned lo, int unsigned hi, bit invalid_only);
    plan_item_t it;
    if ($urandom_range(0, 99) < 15) begin
      it = query_item(16'($urandom), 16'($urandom));
      case ($urandom_range(0, 7))
        0: it.physical_hz = 16'($urandom_range(0, 124));
        1: it.physical_hz = 16'($urandom_range(125, 1000));
        2: it.physical_hz = 16'($urandom_range(1000, 3300));
        3: it.physical_hz = 16'($urandom_range(3150, 3250));
        4: it.physical_hz = 16'($urandom_range(7000, 9000));
        5: it.physical_hz = 16'($urandom_range(20000, 30000));
        default: ;
      endcase
      if ($urandom_range(0, 3) == 0) it.reported_hz = 16'($urandom_range(0, 2));
    end else begin
      it = record_item(16'($urandom));
      if (invalid_only || $urandom_range(0, 9) == 0) begin
        if ($urandom_range(0, 1) == 1)
          it.interval_us = 16'($urandom_range(0, prmsp_pkg::DT_MIN_US - 1));
        else
          it.interval_us = 16'($urandom_range(prmsp_pkg::DT_MAX_US + 1, 65535));
      end else if ($urandom_range(0, 9) != 0) begin
        it.interval_us = 16'($urandom_range(lo, hi));
      end
    end
    return it;
  endfunction

  // Drive one item at the clock edge and hold it until the transfer.
  task automatic push_item(input plan_item_t it);
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {it.reported_hz, it.physical_hz, it.interval_us};
    s_axis_tuser_i  <= it.op;
    do @(posedge clk_i); while (!s_axis_tready_o);
    sb.note_input(it);
  endtask

  // Sender pause: every pending plan delivered, then a few cycles for a last record.
  task automatic drain();
    s_axis_tvalid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_rate_limit(input logic [15:0] value);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    sb.write_limit(value);
  endtask

  // Random items in bursts; the interval band moves so the ring minimum varies.
  task automatic run_random(input int unsigned count, input bit invalid_only);
    int unsigned lo;
    int unsigned hi;
    int unsigned gap;
    lo = 20;
    hi = 60;
    for (int unsigned n = 0; n < count; n++) begin
      if (n % BAND_ITEMS == 0) begin
        case ($urandom_range(0, 5))
          0: begin lo = 20;   hi = 60;    end
          1: begin lo = 40;   hi = 400;   end
          2: begin lo = 300;  hi = 3000;  end
          3: begin lo = 2000; hi = 20000; end
          4: begin lo = 8000; hi = 50000; end
          default: begin lo = 0; hi = 65535; end
        endcase
      end
      if (burst_left == 0) begin
        burst_left = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 24);
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
        if (gap != 0) begin
          s_axis_tvalid_i <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
      end
      burst_left--;
      push_item(random_item(lo, hi, invalid_only));
    end
  endtask

  initial begin : stimulus
    logic [15:0] limits [9];
    limits = '{16'd0, 16'd65535, 16'd999, 16'd1000, 16'd7499, 16'd7500, 16'd8000,
               16'd8001, 16'($urandom)};

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed, at the reset limit of 8000 Hz.
    push_item(query_item(16'd0, 16'd0));          // empty ring, fallback to default
    push_item(query_item(16'd0, 16'd1));          // reported of 1 also gives default
    push_item(query_item(16'd0, 16'd2));          // tiny fallback, rate below floor
    push_item(query_item(16'd65535, 16'd65535));  // everything at the top
    push_item(record_item(16'd19));               // out-of-range samples only
    push_item(record_item(16'd50001));
    push_item(record_item(16'd0));
    push_item(record_item(16'd65535));
    push_item(query_item(16'd100, 16'd500));      // ring holds only rejects: fallback
    push_item(record_item(16'd50000));            // longest valid: peak clamps to 125
    push_item(query_item(16'd0, 16'd0));
    push_item(record_item(16'd3000));             // peak 333
    push_item(query_item(16'd3199, 16'd0));       // slow rate: forced step maximum
    push_item(query_item(16'd3200, 16'd0));       // just past the forcing threshold
    push_item(record_item(16'd20));               // shortest valid: peak clamps to 24000
    push_item(query_item(16'd65535, 16'd0));      // output rate cap
    push_item(query_item(16'd24000, 16'd0));

    // Random phases, one rate limit each; the fourth stores only rejected intervals.
    for (int unsigned p = 0; p < 9; p++) begin
      drain();
      write_rate_limit(limits[p]);
      run_random(PHASE_ITEMS, p == 3);
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (sb.pending() != 0)
      $display("%0t: %0d plans never delivered", $time, sb.pending());
    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// File: filelist.f
sv/prmsp_pkg.sv
sv/prmsp_div.sv
sv/poll_rate_micro_step_planner_top.sv
dv/tb_top.sv
